// ===== src/nst_pkg.sv =====
// Shared types and constants for the named semaphore table.
// No dependencies; the top level and the testbench files refer to this package.
`timescale 1ns / 1ps
`default_nettype none

package nst_pkg;

	localparam int SLOT_COUNT_DEF       = 16;
	localparam int WAITERS_PER_SLOT_DEF = 16;
	localparam int NAME_BITS_DEF        = 64;

	localparam int IN_TDATA_W  = 152;
	localparam int OUT_TDATA_W = 64;
	localparam int COUNT_W     = 16;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_WAIT   = 2'd1,
		OP_SIGNAL = 2'd2,
		OP_FREE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_EXISTS     = 3'd1,
		ST_FULL       = 3'd2,
		ST_NOT_EXISTS = 3'd3,
		ST_QUEUE_FULL = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_OPER,
		FSM_REL
	} fsm_t;

endpackage

`default_nettype wire

// ===== src/named_semaphore_table_top.sv =====
// Top level of the named semaphore table: control sequencer and three RAMs.
// Depends on nst_pkg and nst_ram.
`timescale 1ns / 1ps
`default_nettype none

// A table of SLOT_COUNT counting semaphores keyed by owner id and name, each with a
// FIFO of up to WAITERS_PER_SLOT blocked callers. One request beat gives one result
// beat. Keys live in a RAM that is searched one slot per cycle; create, wait and
// signal load their result once the search has run to the last slot or a match has
// ended it early. The next request is taken when the sequencer is back in idle after
// loading the result. A signal that releases a waiter adds a release state for the
// waiter RAM read. Free skips the search and loads its result from the operate state.
// A result is loaded only while the output register is empty or being accepted, so a
// result that still waits unaccepted there holds the sequencer.
// One request is in work at a time; a new request is taken while the previous
// result still waits at the output register.
module named_semaphore_table_top #(
	parameter int SLOT_COUNT       = nst_pkg::SLOT_COUNT_DEF,
	parameter int WAITERS_PER_SLOT = nst_pkg::WAITERS_PER_SLOT_DEF,
	parameter int NAME_BITS        = nst_pkg::NAME_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// owner_id, name_key, initial_count, caller_env, free_slot (lowest bit up)
	input  wire logic [nst_pkg::IN_TDATA_W-1:0] s_tdata,
	// op
	input  wire logic [1:0]                     s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// status, slot_index, count_after, caller_blocked, released_valid, released_env
	output logic [nst_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	localparam int SW  = $clog2(SLOT_COUNT);
	localparam int HW  = (WAITERS_PER_SLOT > 1) ? $clog2(WAITERS_PER_SLOT) : 1;
	localparam int FW  = $clog2(WAITERS_PER_SLOT + 1);
	localparam int PW  = FW + 1;
	localparam int WD  = SLOT_COUNT * WAITERS_PER_SLOT;
	localparam int AW  = $clog2(WD);
	localparam int KW  = 32 + NAME_BITS;
	localparam int CW  = nst_pkg::COUNT_W;
	localparam int STW = CW + HW + FW;

	nst_pkg::fsm_t state_q, state_d;

	nst_pkg::op_t          op_q;
	logic [31:0]           owner_q;
	logic [NAME_BITS-1:0]  name_q;
	logic [15:0]           init_q;
	logic [31:0]           caller_q;
	logic [3:0]            fslot_q;

	logic [SW-1:0]         scan_q;
	logic                  chk_s1;
	logic [SW-1:0]         idx_s1;
	logic                  found_q;
	logic [SW-1:0]         slot_q;
	logic                  free_found_q;
	logic [SW-1:0]         free_idx_q;
	logic [SLOT_COUNT-1:0] used_q;
	logic signed [CW-1:0]  cnt_q;

	logic                  out_valid_q;
	nst_pkg::status_t      out_status_q;
	logic [3:0]            out_slot_q;
	logic signed [CW-1:0]  out_cnt_q;
	logic                  out_blk_q;
	logic                  out_rv_q;
	logic [31:0]           out_renv_q;

	logic                  key_re, key_we, st_re, st_we, wt_re, wt_we;
	logic [SW-1:0]         key_waddr, st_raddr, st_waddr;
	logic [KW-1:0]         key_rdata, key_wdata;
	logic [STW-1:0]        st_rdata, st_wdata;
	logic [AW-1:0]         wt_raddr, wt_waddr;
	logic [31:0]           wt_rdata;

	logic                  accept, out_free, out_load, hit, used_set, used_clr, fslot_ok;
	nst_pkg::status_t      o_status;
	logic [3:0]            o_slot;
	logic signed [CW-1:0]  o_cnt;
	logic                  o_blk, o_rv;
	logic [31:0]           o_renv;

	logic signed [CW-1:0]  cur_cnt, dec_cnt, inc_cnt, sat_init;
	logic [HW-1:0]         cur_head, head_nx, pos;
	logic [FW-1:0]         cur_fill;
	logic [PW-1:0]         pos_sum;
	logic                  q_full;
	logic [AW-1:0]         slot_base;

	assign s_tready = (state_q == nst_pkg::FSM_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_renv_q, out_rv_q, out_blk_q, out_cnt_q, out_slot_q,
		out_status_q};

	assign hit = chk_s1 && used_q[idx_s1] && (key_rdata == {owner_q, name_q});
	assign fslot_ok = (9'(fslot_q) < 9'(SLOT_COUNT));

	// Slot state word: count in the low bits, then queue head, then fill.
	assign cur_cnt  = st_rdata[CW-1:0];
	assign cur_head = st_rdata[CW +: HW];
	assign cur_fill = st_rdata[CW+HW +: FW];

	assign dec_cnt  = (cur_cnt == 16'sh8000) ? cur_cnt : cur_cnt - 16'sd1;
	assign inc_cnt  = (cur_cnt == 16'sh7FFF) ? cur_cnt : cur_cnt + 16'sd1;
	assign sat_init = init_q[15] ? 16'sh7FFF : $signed(init_q);
	assign q_full   = (cur_fill >= FW'(WAITERS_PER_SLOT));

	// Head and fill are both below the depth here, so one subtract wraps the sum.
	assign pos_sum = PW'(cur_head) + PW'(cur_fill);
	assign pos     = (pos_sum >= PW'(WAITERS_PER_SLOT)) ?
		HW'(pos_sum - PW'(WAITERS_PER_SLOT)) : HW'(pos_sum);
	assign head_nx = (cur_head == HW'(WAITERS_PER_SLOT - 1)) ? '0 : cur_head + HW'(1);
	assign slot_base = AW'(slot_q) * AW'(WAITERS_PER_SLOT);

	always_comb begin
		state_d   = state_q;
		key_re    = 1'b0;
		key_we    = 1'b0;
		key_waddr = free_idx_q;
		key_wdata = {owner_q, name_q};
		st_re     = 1'b0;
		st_raddr  = idx_s1;
		st_we     = 1'b0;
		st_waddr  = slot_q;
		st_wdata  = st_rdata;
		wt_re     = 1'b0;
		wt_raddr  = slot_base + AW'(cur_head);
		wt_we     = 1'b0;
		wt_waddr  = slot_base + AW'(pos);
		used_set  = 1'b0;
		used_clr  = 1'b0;
		out_load  = 1'b0;
		o_status  = nst_pkg::ST_OK;
		o_slot    = 4'(slot_q);
		o_cnt     = '0;
		o_blk     = 1'b0;
		o_rv      = 1'b0;
		o_renv    = '0;
		case (state_q)
			nst_pkg::FSM_IDLE: begin
				if (s_tvalid) begin
					state_d = (nst_pkg::op_t'(s_tuser) == nst_pkg::OP_FREE) ?
						nst_pkg::FSM_OPER : nst_pkg::FSM_SCAN;
				end
			end
			nst_pkg::FSM_SCAN: begin
				key_re = 1'b1;
				if (hit) begin
					st_re   = 1'b1;
					state_d = nst_pkg::FSM_OPER;
				end else if (chk_s1 && idx_s1 == SW'(SLOT_COUNT - 1)) begin
					state_d = nst_pkg::FSM_OPER;
				end
			end
			nst_pkg::FSM_OPER: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = nst_pkg::FSM_IDLE;
					case (op_q)
						nst_pkg::OP_FREE: begin
							o_slot = fslot_q;
							if (fslot_ok) begin
								used_clr = 1'b1;
							end else begin
								o_status = nst_pkg::ST_NOT_EXISTS;
							end
						end
						nst_pkg::OP_CREATE: begin
							if (found_q) begin
								o_status = nst_pkg::ST_EXISTS;
								o_cnt    = cur_cnt;
							end else if (free_found_q) begin
								key_we   = 1'b1;
								st_we    = 1'b1;
								st_waddr = free_idx_q;
								st_wdata = {FW'(0), HW'(0), sat_init};
								used_set = 1'b1;
								o_slot   = 4'(free_idx_q);
								o_cnt    = sat_init;
							end else begin
								o_status = nst_pkg::ST_FULL;
								o_slot   = '0;
							end
						end
						nst_pkg::OP_WAIT: begin
							if (!found_q) begin
								o_status = nst_pkg::ST_NOT_EXISTS;
								o_slot   = '0;
							end else if (dec_cnt < 0 && q_full) begin
								o_status = nst_pkg::ST_QUEUE_FULL;
								o_cnt    = cur_cnt;
							end else begin
								st_we = 1'b1;
								o_cnt = dec_cnt;
								if (dec_cnt < 0) begin
									wt_we    = 1'b1;
									st_wdata = {cur_fill + FW'(1), cur_head, dec_cnt};
									o_blk    = 1'b1;
								end else begin
									st_wdata = {cur_fill, cur_head, dec_cnt};
								end
							end
						end
						default: begin
							if (!found_q) begin
								o_status = nst_pkg::ST_NOT_EXISTS;
								o_slot   = '0;
							end else if (inc_cnt <= 0 && cur_fill != '0) begin
								// The released id is read from the waiter RAM and loaded in the release state.
								out_load = 1'b0;
								st_we    = 1'b1;
								st_wdata = {cur_fill - FW'(1), head_nx, inc_cnt};
								wt_re    = 1'b1;
								state_d  = nst_pkg::FSM_REL;
							end else begin
								st_we    = 1'b1;
								st_wdata = {cur_fill, cur_head, inc_cnt};
								o_cnt    = inc_cnt;
							end
						end
					endcase
				end
			end
			default: begin
				if (out_free) begin
					out_load = 1'b1;
					o_cnt    = cnt_q;
					o_rv     = 1'b1;
					o_renv   = wt_rdata;
					state_d  = nst_pkg::FSM_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nst_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			out_valid_q <= 1'b0;
			chk_s1      <= 1'b0;
		end else begin
			if (used_set) begin
				used_q[free_idx_q] <= 1'b1;
			end
			if (used_clr) begin
				used_q[SW'(fslot_q)] <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				chk_s1 <= 1'b0;
			end else if (state_q == nst_pkg::FSM_SCAN) begin
				chk_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= nst_pkg::op_t'(s_tuser);
			owner_q      <= s_tdata[31:0];
			name_q       <= s_tdata[32 +: NAME_BITS];
			init_q       <= s_tdata[111:96];
			caller_q     <= s_tdata[143:112];
			fslot_q      <= s_tdata[147:144];
			scan_q       <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end
		if (state_q == nst_pkg::FSM_SCAN) begin
			idx_s1 <= scan_q;
			if (scan_q != SW'(SLOT_COUNT - 1)) begin
				scan_q <= scan_q + SW'(1);
			end
			if (hit) begin
				found_q <= 1'b1;
				slot_q  <= idx_s1;
			end
			if (chk_s1 && !used_q[idx_s1] && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
		end
		if (state_q == nst_pkg::FSM_OPER) begin
			cnt_q <= inc_cnt;
		end
		if (out_load) begin
			out_status_q <= o_status;
			out_slot_q   <= o_slot;
			out_cnt_q    <= o_cnt;
			out_blk_q    <= o_blk;
			out_rv_q     <= o_rv;
			out_renv_q   <= o_renv;
		end
	end

	nst_ram #(.WIDTH(KW), .DEPTH(SLOT_COUNT), .AW(SW)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.re    (key_re),
		.raddr (scan_q),
		.rdata (key_rdata)
	);

	nst_ram #(.WIDTH(STW), .DEPTH(SLOT_COUNT), .AW(SW)) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	nst_ram #(.WIDTH(32), .DEPTH(WD), .AW(AW)) u_waiter_ram (
		.clk   (clk),
		.we    (wt_we),
		.waddr (wt_waddr),
		.wdata (caller_q),
		.re    (wt_re),
		.raddr (wt_raddr),
		.rdata (wt_rdata)
	);

endmodule

`default_nettype wire

// ===== src/nst_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Used for the key, slot state and waiter stores of the semaphore table.
`timescale 1ns / 1ps
`default_nettype none

module nst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== tb/named_semaphore_table_checker.sv =====
// Checker for the named semaphore table: watches both streams, models the table
// and compares every result beat against its prediction. Depends on nst_pkg.
`timescale 1ns / 1ps

module named_semaphore_table_checker
	import nst_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic [1:0]             s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	output int                     fail_count,
	output int                     pending
);

	localparam int NSLOT = SLOT_COUNT_DEF;
	localparam int NWAIT = WAITERS_PER_SLOT_DEF;

	typedef struct packed {
		logic [31:0] released_env;
		logic        released_valid;
		logic        caller_blocked;
		logic [15:0] count_after;
		logic [3:0]  slot_index;
		logic [2:0]  status;
	} sem_result_t;

	logic              used_tbl  [NSLOT];
	logic [31:0]       owner_tbl [NSLOT];
	logic [63:0]       name_tbl  [NSLOT];
	int                count_tbl [NSLOT];
	logic [31:0]       waiters   [NSLOT][NWAIT];
	int                head_tbl  [NSLOT];
	int                fill_tbl  [NSLOT];
	sem_result_t       result_queue[$];

	int n_blocked, n_released, n_qfull, n_tfull;

	assign pending = result_queue.size();

	function automatic int lookup_key(logic [31:0] owner, logic [63:0] name);
		for (int i = 0; i < NSLOT; i++)
			if (used_tbl[i] && owner_tbl[i] == owner && name_tbl[i] == name)
				return i;
		return -1;
	endfunction

	function automatic void wipe_slot(int s);
		used_tbl[s] = 1'b0;
		count_tbl[s] = 0;
		head_tbl[s] = 0;
		fill_tbl[s] = 0;
	endfunction

	function automatic sem_result_t apply_request(op_t op, logic [IN_TDATA_W-1:0] d);
		sem_result_t r;
		logic [31:0] owner, caller;
		logic [63:0] name;
		logic [15:0] init;
		logic [3:0]  fslot;
		int s, nc;
		owner  = d[31:0];
		name   = d[95:32];
		init   = d[111:96];
		caller = d[143:112];
		fslot  = d[147:144];
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_CREATE: begin
				s = lookup_key(owner, name);
				if (s >= 0) begin
					r.status = ST_EXISTS;
					r.slot_index = s[3:0];
					r.count_after = count_tbl[s][15:0];
				end else begin
					s = -1;
					for (int i = 0; i < NSLOT; i++)
						if (s < 0 && !used_tbl[i]) s = i;
					if (s < 0) begin
						r.status = ST_FULL;
						n_tfull++;
					end else begin
						wipe_slot(s);
						used_tbl[s] = 1'b1;
						owner_tbl[s] = owner;
						name_tbl[s] = name;
						count_tbl[s] = init > 16'd32767 ? 32767 : int'(init);
						r.slot_index = s[3:0];
						r.count_after = count_tbl[s][15:0];
					end
				end
			end
			OP_WAIT, OP_SIGNAL: begin
				s = lookup_key(owner, name);
				if (s < 0) begin
					r.status = ST_NOT_EXISTS;
				end else begin
					r.slot_index = s[3:0];
					if (op == OP_WAIT) begin
						nc = count_tbl[s] > -32768 ? count_tbl[s] - 1 : -32768;
						if (nc < 0) begin
							if (fill_tbl[s] >= NWAIT) begin
								r.status = ST_QUEUE_FULL;
								nc = count_tbl[s];
								n_qfull++;
							end else begin
								waiters[s][(head_tbl[s] + fill_tbl[s]) % NWAIT] = caller;
								fill_tbl[s]++;
								r.caller_blocked = 1'b1;
								n_blocked++;
							end
						end
						count_tbl[s] = nc;
					end else begin
						nc = count_tbl[s] < 32767 ? count_tbl[s] + 1 : 32767;
						count_tbl[s] = nc;
						if (nc <= 0 && fill_tbl[s] > 0) begin
							r.released_env = waiters[s][head_tbl[s]];
							r.released_valid = 1'b1;
							head_tbl[s] = (head_tbl[s] + 1) % NWAIT;
							fill_tbl[s]--;
							n_released++;
						end
					end
					r.count_after = count_tbl[s][15:0];
				end
			end
			default: begin
				r.slot_index = fslot;
				if (int'(fslot) >= NSLOT) r.status = ST_NOT_EXISTS;
				else wipe_slot(int'(fslot));
			end
		endcase
		return r;
	endfunction

	initial begin
		fail_count = 0;
		n_blocked = 0;
		n_released = 0;
		n_qfull = 0;
		n_tfull = 0;
		for (int i = 0; i < NSLOT; i++) wipe_slot(i);
	end

	always @(posedge clk) begin
		sem_result_t got, want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				result_queue.push_back(apply_request(op_t'(s_tuser), s_tdata));
			if (m_tvalid && m_tready) begin
				got = sem_result_t'(m_tdata[$bits(sem_result_t)-1:0]);
				if (result_queue.size() == 0) begin
					$display("%0t: result beat with nothing expected: %h", $time, m_tdata);
					fail_count++;
				end else begin
					want = result_queue.pop_front();
					if (got.status != want.status) begin
						$display("%0t: status expected %0d got %0d", $time,
							want.status, got.status);
						fail_count++;
					end
					if (got.slot_index != want.slot_index) begin
						$display("%0t: slot_index expected %0d got %0d", $time,
							want.slot_index, got.slot_index);
						fail_count++;
					end
					if (got.count_after != want.count_after) begin
						$display("%0t: count_after expected %0d got %0d", $time,
							$signed(want.count_after), $signed(got.count_after));
						fail_count++;
					end
					if (got.caller_blocked != want.caller_blocked) begin
						$display("%0t: caller_blocked expected %0b got %0b", $time,
							want.caller_blocked, got.caller_blocked);
						fail_count++;
					end
					if (got.released_valid != want.released_valid) begin
						$display("%0t: released_valid expected %0b got %0b", $time,
							want.released_valid, got.released_valid);
						fail_count++;
					end
					if (got.released_env != want.released_env) begin
						$display("%0t: released_env expected %h got %h", $time,
							want.released_env, got.released_env);
						fail_count++;
					end
					if (m_tdata[OUT_TDATA_W-1:$bits(sem_result_t)] != '0) begin
						$display("%0t: padding expected 0 got %h", $time,
							m_tdata[OUT_TDATA_W-1:$bits(sem_result_t)]);
						fail_count++;
					end
				end
			end
		end
	end

	function automatic void report_coverage();
		$display("Coverage: %0d blocked waits, %0d releases, %0d queue-full, %0d table-full",
			n_blocked, n_released, n_qfull, n_tfull);
	endfunction

endmodule

// ===== tb/named_semaphore_table_top_test.sv =====
// Top of the named semaphore table testbench: clock, reset, request stimulus and
// verdict. Depends on nst_pkg, named_semaphore_table_top and the checker module.
`timescale 1ns / 1ps

module named_semaphore_table_top_test;
	import nst_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [1:0]             s_tuser = OP_CREATE;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	int                     fail_count, pending;

	bit quiet_mode = 1'b0;
	bit long_hold = 1'b0;

	// A small pool of keys so that creates collide and waits find their slot.
	logic [31:0] pool_owner [8];
	logic [63:0] pool_name  [8];

	always #1 clk = ~clk;

	named_semaphore_table_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	named_semaphore_table_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	// Receiver: random stall bursts, one long hold-off on request.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
				m_tready <= 1'b1;
			end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 7);
				m_tready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_request(op_t op, logic [31:0] owner, logic [63:0] name,
			logic [15:0] init, logic [31:0] caller, logic [3:0] fslot);
		int gap;
		if (!quiet_mode && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 7);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, fslot, caller, init, name, owner};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_request(int bias);
		int k, pick;
		op_t op;
		logic [31:0] owner;
		logic [63:0] name;
		k = $urandom_range(0, 7);
		owner = pool_owner[k];
		name = pool_name[k];
		pick = $urandom_range(0, 99);
		if (pick < 15) op = OP_CREATE;
		else if (pick < 15 + bias) op = OP_WAIT;
		else if (pick < 92) op = OP_SIGNAL;
		else op = OP_FREE;
		// Occasional unknown keys.
		if ($urandom_range(0, 19) == 0) begin
			owner = $urandom();
			name = {$urandom(), $urandom()};
		end
		send_request(op, owner, name,
			$urandom_range(0, 9) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 3)),
			$urandom(), 4'($urandom()));
	endtask

	initial begin
		for (int i = 0; i < 8; i++) begin
			pool_owner[i] = $urandom();
			pool_name[i] = {$urandom(), $urandom()};
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, saturation, queue full, missing keys, free.
		send_request(OP_CREATE, '1, '1, 16'hFFFF, '0, '0);
		send_request(OP_SIGNAL, '1, '1, '0, '0, '0);
		send_request(OP_CREATE, '1, '1, 16'd5, '0, '0);
		send_request(OP_CREATE, '0, '0, 16'd0, '0, '0);
		for (int i = 0; i < 17; i++)
			send_request(OP_WAIT, '0, '0, '0, 32'hA5A5_0000 + i, '0);
		send_request(OP_SIGNAL, '0, '0, '0, '0, '0);
		send_request(OP_WAIT, 32'h1234, 64'h55, '0, '1, '0);
		send_request(OP_SIGNAL, 32'h1234, 64'h55, '0, '0, '0);
		send_request(OP_FREE, '0, '0, '0, '0, 4'd15);
		send_request(OP_FREE, '0, '0, '0, '0, 4'd0);
		drain_results();

		// Fill the table and overflow it, then empty it again.
		for (int i = 0; i < 17; i++)
			send_request(OP_CREATE, 32'(i), 64'(i) << 40, 16'(i), '0, '0);
		for (int i = 0; i < 16; i++)
			send_request(OP_FREE, '0, '0, '0, '0, 4'(i));

		// Output hold-off while requests keep coming.
		long_hold = 1'b1;
		for (int i = 0; i < 120; i++) random_request(40);
		drain_results();
		for (int i = 0; i < 330; i++) random_request(i < 165 ? 45 : 25);

		quiet_mode = 1'b1;
		for (int i = 0; i < 80; i++) random_request(38);
		drain_results();
		repeat (40) @(posedge clk);

		u_chk.report_coverage();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
